// File: sv/tmavg_pkg.sv
// Package with the sample type and the shared constants of the moving average unit.
`timescale 1ns / 1ps
package tmavg_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int WINDOW_DEF = 35;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [SAMPLE_W-1:0] x;
    logic [SAMPLE_W-1:0] y;
    logic [SAMPLE_W-1:0] z;
  } smp_t;

  typedef struct packed {
    logic valid;
    smp_t item;
  } q_t;

endpackage

// File: sv/tmavg_front.sv
// Front end: accepts sample items and queues them for the back end.
`timescale 1ns / 1ps
module tmavg_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [15:0]           in_sample_x,
  input  logic signed [15:0]           in_sample_y,
  input  logic signed [15:0]           in_sample_z,
  output tmavg_pkg::q_t                q_out,
  input  logic                         q_pop
);
  import tmavg_pkg::*;

  localparam logic [QCNT_W-1:0] Q_FULL = QCNT_W'(QDEPTH);
  localparam logic [QPTR_W-1:0] Q_LAST = QPTR_W'(QDEPTH - 1);

  smp_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  logic              pop;

  assign in_stall    = (cnt_r == Q_FULL);
  assign push        = in_valid && !in_stall;
  assign pop         = q_pop && (cnt_r != '0);
  assign q_out.valid = (cnt_r != '0);
  assign q_out.item  = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= '{x: in_sample_x, y: in_sample_y, z: in_sample_z};
    end
  end

endmodule

// File: sv/tmavg_div.sv
// Iterative signed divider that truncates toward zero, one quotient bit per cycle.
`timescale 1ns / 1ps
module tmavg_div #(
  parameter int DVD_W = 22,
  parameter int DVS_W = 6,
  parameter int QUO_W = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [DVD_W-1:0] dividend,
  input  logic        [DVS_W-1:0] divisor,
  output logic                    done,
  output logic        [QUO_W-1:0] quotient
);
  import tmavg_pkg::*;

  localparam int ITER_W = $clog2(DVD_W + 1);
  localparam logic [ITER_W-1:0] ITERS = ITER_W'(DVD_W);

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t           state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic              neg_r, neg_nxt;
  logic              done_r, done_nxt;
  logic [QUO_W-1:0]  res_r, res_nxt;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              ge;
  logic [DVS_W-1:0]  rem_step;
  logic [DVD_W-1:0]  quo_step;
  logic [DVD_W-1:0]  mag;
  logic [QUO_W-1:0]  res_mag;

  assign mag      = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
  assign trial    = {rem_r, quo_r[DVD_W-1]};
  assign diff     = trial - {1'b0, dvs_r};
  assign ge       = (trial >= {1'b0, dvs_r});
  assign rem_step = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  assign quo_step = {quo_r[DVD_W-2:0], ge};
  assign res_mag  = quo_step[QUO_W-1:0];

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    dvs_nxt   = dvs_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    neg_nxt   = neg_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;
    case (state_r)
      D_IDLE: begin
        if (start) begin
          dvs_nxt   = divisor;
          rem_nxt   = '0;
          quo_nxt   = mag;
          neg_nxt   = dividend[DVD_W-1];
          iter_nxt  = ITERS;
          state_nxt = D_RUN;
        end
      end
      D_RUN: begin
        rem_nxt  = rem_step;
        quo_nxt  = quo_step;
        iter_nxt = iter_r - 1'b1;
        if (iter_r == ITER_W'(1)) begin
          res_nxt   = neg_r ? QUO_W'(-res_mag) : res_mag;
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      iter_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
      done_r  <= done_nxt;
    end
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign done     = done_r;
  assign quotient = res_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == D_IDLE))
    else $error("divider started while busy");

  a_nonzero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == D_RUN) |-> (dvs_r != '0))
    else $error("divider running with a zero divisor");

  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(state_r) == D_RUN) && (state_r == D_IDLE))
    else $error("divider done without a finished run");

endmodule

// File: sv/tmavg_back.sv
// Back end: window store, running sums, averaging and the result register.
`timescale 1ns / 1ps
module tmavg_back #(
  parameter int WINDOW = tmavg_pkg::WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tmavg_pkg::q_t        q_in,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   out_avg_x,
  output logic signed [15:0]   out_avg_y,
  output logic signed [15:0]   out_avg_z
);
  import tmavg_pkg::*;

  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = SAMPLE_W + CNT_W;
  localparam logic [CNT_W-1:0]  WIN_CNT   = CNT_W'(WINDOW);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  typedef enum logic [1:0] {S_IDLE, S_UPD, S_DIV, S_OUT} state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [SLOT_W-1:0]       oldest_r, oldest_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic                    full_r, full_nxt;
  smp_t                    smp_r, smp_nxt;
  logic signed [SUM_W-1:0] tot_x_r, tot_x_nxt;
  logic signed [SUM_W-1:0] tot_y_r, tot_y_nxt;
  logic signed [SUM_W-1:0] tot_z_r, tot_z_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]     out_x_r, out_x_nxt;
  logic [SAMPLE_W-1:0]     out_y_r, out_y_nxt;
  logic [SAMPLE_W-1:0]     out_z_r, out_z_nxt;

  smp_t                    win_mem [WINDOW];
  smp_t                    rd_r;

  logic                    full_cur;
  logic [SLOT_W-1:0]       slot_cur;
  logic signed [SUM_W-1:0] old_x, old_y, old_z;
  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
  logic [CNT_W-1:0]        div_n;
  logic                    div_start;
  logic                    done_x, done_y, done_z;
  logic [SAMPLE_W-1:0]     quo_x, quo_y, quo_z;

  function automatic logic signed [SUM_W-1:0] sext(input logic [SAMPLE_W-1:0] v);
    return {{(SUM_W - SAMPLE_W){v[SAMPLE_W-1]}}, v};
  endfunction

  assign full_cur  = (count_r == WIN_CNT);
  assign slot_cur  = full_cur ? oldest_r : count_r[SLOT_W-1:0];
  assign q_pop     = (state_r == S_IDLE) && q_in.valid;
  assign old_x     = full_r ? sext(rd_r.x) : '0;
  assign old_y     = full_r ? sext(rd_r.y) : '0;
  assign old_z     = full_r ? sext(rd_r.z) : '0;
  assign sum_x     = tot_x_r - old_x + sext(smp_r.x);
  assign sum_y     = tot_y_r - old_y + sext(smp_r.y);
  assign sum_z     = tot_z_r - old_z + sext(smp_r.z);
  assign div_n     = full_r ? WIN_CNT : count_r + 1'b1;
  assign div_start = (state_r == S_UPD);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    oldest_nxt    = oldest_r;
    slot_nxt      = slot_r;
    full_nxt      = full_r;
    smp_nxt       = smp_r;
    tot_x_nxt     = tot_x_r;
    tot_y_nxt     = tot_y_r;
    tot_z_nxt     = tot_z_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_z_nxt     = out_z_r;
    case (state_r)
      S_IDLE: begin
        if (q_in.valid) begin
          smp_nxt   = q_in.item;
          slot_nxt  = slot_cur;
          full_nxt  = full_cur;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        tot_x_nxt = sum_x;
        tot_y_nxt = sum_y;
        tot_z_nxt = sum_z;
        if (full_r) begin
          oldest_nxt = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
        end else begin
          count_nxt  = count_r + 1'b1;
          oldest_nxt = '0;
        end
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (done_x && done_y && done_z) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = quo_x;
          out_y_nxt     = quo_y;
          out_z_nxt     = quo_z;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      oldest_r    <= '0;
      tot_x_r     <= '0;
      tot_y_r     <= '0;
      tot_z_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      oldest_r    <= oldest_nxt;
      tot_x_r     <= tot_x_nxt;
      tot_y_r     <= tot_y_nxt;
      tot_z_r     <= tot_z_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slot_r  <= slot_nxt;
    full_r  <= full_nxt;
    smp_r   <= smp_nxt;
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
    out_z_r <= out_z_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_r <= win_mem[slot_cur];
    end
    if (state_r == S_UPD) begin
      win_mem[slot_r] <= smp_r;
    end
  end

  tmavg_div #(.DVD_W(SUM_W), .DVS_W(CNT_W), .QUO_W(SAMPLE_W)) u_div_x (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_x), .divisor(div_n),
    .done(done_x), .quotient(quo_x)
  );

  tmavg_div #(.DVD_W(SUM_W), .DVS_W(CNT_W), .QUO_W(SAMPLE_W)) u_div_y (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_y), .divisor(div_n),
    .done(done_y), .quotient(quo_y)
  );

  tmavg_div #(.DVD_W(SUM_W), .DVS_W(CNT_W), .QUO_W(SAMPLE_W)) u_div_z (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_z), .divisor(div_n),
    .done(done_z), .quotient(quo_z)
  );

  assign out_valid = out_valid_r;
  assign out_avg_x = out_x_r;
  assign out_avg_y = out_y_r;
  assign out_avg_z = out_z_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= WIN_CNT)
    else $error("sample count beyond window");

  a_oldest_while_filling: assert property (@(posedge clk) disable iff (!rst_n)
    !full_cur |-> (oldest_r == '0))
    else $error("oldest slot moved before the window was full");

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (done_x == done_y) && (done_y == done_z))
    else $error("axis dividers out of step");

  a_done_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    done_x |-> (state_r == S_DIV))
    else $error("quotient ready outside the divide state");

endmodule

// File: sv/three_axis_moving_average_unit.sv
// Top level of the three-axis moving average unit.
// An item passes from the queue through the update, divide and output states to the result
// register. The back end takes one item at a time; its one-bit-per-cycle dividers work on
// a SUM_W-bit sum, where SUM_W is 16 plus the bits needed to count WINDOW samples.
// A two-entry queue takes items while the back end works, and the result register holds.
// Synchronous active-low reset clears the sums, the count and the queue; no clearing pass.
`timescale 1ns / 1ps
module three_axis_moving_average_unit #(
  parameter int WINDOW = tmavg_pkg::WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sample_x,
  input  logic signed [15:0] in_sample_y,
  input  logic signed [15:0] in_sample_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_avg_x,
  output logic signed [15:0] out_avg_y,
  output logic signed [15:0] out_avg_z
);
  import tmavg_pkg::*;

  q_t   q_link;
  logic q_pop;

  tmavg_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_sample_x (in_sample_x),
    .in_sample_y (in_sample_y),
    .in_sample_z (in_sample_z),
    .q_out       (q_link),
    .q_pop       (q_pop)
  );

  tmavg_back #(.WINDOW(WINDOW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_in      (q_link),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_avg_x (out_avg_x),
    .out_avg_y (out_avg_y),
    .out_avg_z (out_avg_z)
  );

endmodule

// File: dv/three_axis_moving_average_unit_tb.sv
// Self-checking testbench that streams samples through the three-axis moving average unit.
`timescale 1ns / 1ps
module three_axis_moving_average_unit_tb;

  localparam int WINDOW     = tmavg_pkg::WINDOW_DEF;
  localparam int LONG_HOLD  = 300;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE     = 60;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] in_sample_x;
  logic signed [15:0] in_sample_y;
  logic signed [15:0] in_sample_z;
  logic out_valid;
  logic out_stall;
  logic signed [15:0] out_avg_x;
  logic signed [15:0] out_avg_y;
  logic signed [15:0] out_avg_z;

  tmavg_pkg::smp_t mean_q[$];
  tmavg_pkg::smp_t got_mean;
  tmavg_pkg::smp_t want_mean;

  logic signed [15:0] hist [3][WINDOW];
  longint run_sum [3];
  int held;
  int oldest;

  int mismatches = 0;
  int quiet_cycles = 0;
  bit in_idle = 1'b1;
  bit out_idle = 1'b1;
  bit hold_req = 1'b0;

  three_axis_moving_average_unit #(
    .WINDOW(WINDOW)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample_x(in_sample_x),
    .in_sample_y(in_sample_y),
    .in_sample_z(in_sample_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_avg_x  (out_avg_x),
    .out_avg_y  (out_avg_y),
    .out_avg_z  (out_avg_z)
  );

  always #4 clk = ~clk;

  // Moves one sample into the window and returns the truncated means.
  function automatic tmavg_pkg::smp_t next_means(tmavg_pkg::smp_t s);
    logic signed [15:0] v [3];
    longint q [3];
    tmavg_pkg::smp_t m;
    int slot;
    bit full;
    v[0] = s.x;
    v[1] = s.y;
    v[2] = s.z;
    full = (held >= WINDOW);
    slot = full ? oldest : held;
    for (int a = 0; a < 3; a++) begin
      if (full) run_sum[a] -= longint'(hist[a][slot]);
      hist[a][slot] = v[a];
      run_sum[a] += longint'(v[a]);
    end
    if (full) begin
      oldest = (slot + 1 >= WINDOW) ? 0 : slot + 1;
    end else begin
      held++;
      oldest = 0;
    end
    for (int a = 0; a < 3; a++) q[a] = run_sum[a] / longint'(held);
    m.x = q[0][15:0];
    m.y = q[1][15:0];
    m.z = q[2][15:0];
    return m;
  endfunction

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(0, 8)) - 4);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic tmavg_pkg::smp_t rand_sample();
    tmavg_pkg::smp_t s;
    s.x = rand_axis();
    s.y = rand_axis();
    s.z = rand_axis();
    return s;
  endfunction

  task automatic send_sample(tmavg_pkg::smp_t s);
    if (in_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_sample_x <= s.x;
    in_sample_y <= s.y;
    in_sample_z <= s.z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mean_q.push_back(next_means(s));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (mean_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(int count);
    repeat (count) send_sample(rand_sample());
  endtask

  task automatic test_directed_fill();
    send_sample({16'h7FFF, 16'h8000, 16'h0000});
    send_sample({16'h7FFF, 16'h8000, 16'hFFFF});
    send_sample({16'hFFFF, 16'h0001, 16'h0000});
    send_sample({16'h0000, 16'h0000, 16'h8000});
    send_sample({16'h8000, 16'h7FFF, 16'h7FFF});
    send_sample({16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_sample({16'h0001, 16'h0001, 16'h0001});
    send_sample({16'hFFFE, 16'h0002, 16'h7FFE});
    send_sample({16'h5555, 16'hAAAA, 16'h0F0F});
    send_sample({16'hAAAA, 16'h5555, 16'hF0F0});
    send_sample({16'h8000, 16'h8000, 16'h8000});
    send_sample({16'h8000, 16'h8000, 16'h8000});
    send_sample({16'h7FFF, 16'h7FFF, 16'h7FFF});
    send_sample({16'h0000, 16'hFFFF, 16'h0001});
    send_sample({16'hFFFD, 16'h0003, 16'h8001});
  endtask

  task automatic test_random_wrap();
    send_random(800);
  endtask

  task automatic test_receiver_hold();
    hold_req = 1'b1;
    send_random(30);
  endtask

  task automatic test_sender_pause();
    send_random(50);
    drain_results();
    send_random(50);
  endtask

  task automatic test_full_scale();
    repeat (40) send_sample({16'h7FFF, 16'h7FFF, 16'h7FFF});
    repeat (40) send_sample({16'h8000, 16'h8000, 16'h8000});
    for (int i = 0; i < 40; i++) begin
      if (i % 2 == 0) send_sample({16'h7FFF, 16'h8000, 16'h7FFF});
      else send_sample({16'h8000, 16'h7FFF, 16'hFFFF});
    end
  endtask

  task automatic test_back_to_back();
    in_idle  = 1'b0;
    out_idle = 1'b0;
    send_random(800);
  endtask

  task automatic report(string what, tmavg_pkg::smp_t want, tmavg_pkg::smp_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d", what,
               $signed(want.x), $signed(want.y), $signed(want.z),
               $signed(got.x), $signed(got.y), $signed(got.z));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      got_mean = {out_avg_x, out_avg_y, out_avg_z};
      if (mean_q.size() == 0) begin
        report("result with no item pending", '0, got_mean);
      end else begin
        want_mean = mean_q.pop_front();
        if (got_mean.x !== want_mean.x || got_mean.y !== want_mean.y ||
            got_mean.z !== want_mean.z) begin
          report("mean mismatch", want_mean, got_mean);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (out_idle && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_sample_x = '0;
    in_sample_y = '0;
    in_sample_z = '0;
    held        = 0;
    oldest      = 0;
    for (int a = 0; a < 3; a++) begin
      run_sum[a] = 0;
      for (int i = 0; i < WINDOW; i++) hist[a][i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_fill();
    test_random_wrap();
    test_receiver_hold();
    test_sender_pause();
    test_full_scale();
    test_back_to_back();
    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && mean_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
